/* rtl/ihla_pkg.sv */
// shared types and constants for the boundary-tag heap allocator
`timescale 1ns / 1ps
`default_nettype none
package ihla_pkg;

  // operation codes
  localparam logic FN_ALLOC = 1'b0;
  localparam logic FN_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;

  // heap layout constants
  localparam int unsigned INIT_CHUNK  = 4096;
  localparam int unsigned FIRST_BP    = 16;
  localparam int unsigned MIN_BLOCK   = 16;
  localparam logic [15:0] CHUNK_RESET = 16'd4096;

  // sequencer states
  typedef enum logic [20:0] {
    S_INIT0    = 21'h000001,
    S_INIT1    = 21'h000002,
    S_INIT2    = 21'h000004,
    S_IDLE     = 21'h000008,
    S_FIT_RD   = 21'h000010,
    S_FIT_CHK  = 21'h000020,
    S_GROW_W0  = 21'h000040,
    S_GROW_W1  = 21'h000080,
    S_GROW_W2  = 21'h000100,
    S_MRG_RP   = 21'h000200,
    S_MRG_RN   = 21'h000400,
    S_MRG_CALC = 21'h000800,
    S_MRG_W0   = 21'h001000,
    S_MRG_W1   = 21'h002000,
    S_PLC_W0   = 21'h004000,
    S_PLC_W1   = 21'h008000,
    S_PLC_W2   = 21'h010000,
    S_PLC_W3   = 21'h020000,
    S_FREE_W0  = 21'h040000,
    S_FREE_W1  = 21'h080000,
    S_DONE     = 21'h100000
  } state_t;

  // where a coalesce returns to
  typedef enum logic [1:0] {
    CTX_INIT = 2'd0,
    CTX_GROW = 2'd1,
    CTX_FREE = 2'd2
  } ctx_t;

endpackage
`default_nettype wire

/* rtl/ihla_ram.sv */
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ihla_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/ihla_alu.sv */
// shared offset adder: a + b + small signed constant
`timescale 1ns / 1ps
`default_nettype none
module ihla_alu #(
  parameter int OW = 19
) (
  input  wire logic [OW-1:0]   a,
  input  wire logic [OW-1:0]   b,
  input  wire logic signed [4:0] c,
  output logic      [OW-1:0]   y
);

  // three-input add with sign-extended constant
  assign y = a + b + {{(OW-5){c[4]}}, c};

endmodule
`default_nettype wire

/* rtl/implicit_list_heap_allocator_top.sv */
// first-fit boundary-tag heap allocator: sequencer, tag memory and shared adder
// allocate: the first-fit walk reads and checks each block header it visits, then the
//   block is placed and answered, or the heap is grown and coalesced first when none fits
// free walks the blocks, then clears the used bit, coalesces and answers;
//   a zero-size request gives its result beat in the cycle right after accept
// throughput: one item at a time, busy high from accept until the done beat
// reset: synchronous; busy stays high after reset while the prologue, epilogue and
//   initial free chunk are written; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module implicit_list_heap_allocator_top #(
  parameter int HEAP_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [15:0] req_size,
  input  wire logic [15:0] free_addr,
  input  wire logic        chunk_we,
  input  wire logic [15:0] chunk_wdata,
  output logic             done,
  output logic [15:0]      block_addr,
  output logic [1:0]       status
);

  localparam int NWORDS = HEAP_BYTES / 4;
  localparam int WAW    = $clog2(NWORDS);
  localparam int OW     = ($clog2(HEAP_BYTES) + 2 > 19) ? $clog2(HEAP_BYTES) + 2 : 19;
  localparam logic [OW-1:0] HEAP_LIM  = OW'(HEAP_BYTES);
  localparam logic [OW-1:0] FIRST_OFS = OW'(ihla_pkg::FIRST_BP);
  localparam logic [OW-1:0] INIT_SZ   = OW'(ihla_pkg::INIT_CHUNK);
  localparam logic [OW-1:0] MIN_BLK   = OW'(ihla_pkg::MIN_BLOCK);
  localparam logic [OW-1:0] ALIGN_MSK = ~OW'(7);
  localparam bit INIT_FITS = (ihla_pkg::FIRST_BP + ihla_pkg::INIT_CHUNK) <= HEAP_BYTES;

  ihla_pkg::state_t state;
  ihla_pkg::ctx_t   ctx;

  logic          func_r;
  logic [15:0]   faddr;
  logic [15:0]   chunk;
  logic [16:0]   asize;
  logic [OW-1:0] bp;
  logic [OW-1:0] sz;
  logic [OW-1:0] brk;
  logic [OW-1:0] prev_w;
  logic [OW-1:0] mstart;
  logic [OW-1:0] mtotal;
  logic [OW-1:0] res_addr;
  logic [1:0]    res_status;

  logic [OW-1:0]       alu_a;
  logic [OW-1:0]       alu_b;
  logic signed [4:0]   alu_c;
  logic [OW-1:0]       alu_y;
  logic                mem_we;
  logic [31:0]         mem_wdata;
  logic [31:0]         mem_rdata;

  // request size rounding and heap extension size
  logic [16:0]   asize_c;
  logic [16:0]   ext_max;
  logic [17:0]   ext_c;
  logic [OW-1:0] grow_sum;
  logic          grow_ok;
  logic [OW-1:0] asize_w;
  logic [OW-1:0] rem;
  logic          split;
  logic [OW-1:0] blk_s;
  logic          blk_used;
  logic [OW-1:0] psz;
  logic [OW-1:0] nsz;

  always_comb begin
    if (req_size <= 16'd8) begin
      asize_c = 17'(ihla_pkg::MIN_BLOCK);
    end else begin
      asize_c = (17'(req_size) + 17'd15) & ~17'd7;
    end
    ext_max  = (asize > 17'(chunk)) ? asize : 17'(chunk);
    ext_c    = ((18'(ext_max) & ~18'd3) + 18'd7) & ~18'd7;
    grow_sum = brk + OW'(ext_c);
    grow_ok  = grow_sum <= HEAP_LIM;
    asize_w  = OW'(asize);
    rem      = sz - asize_w;
    split    = rem >= MIN_BLK;
    blk_s    = mem_rdata[OW-1:0] & ALIGN_MSK;
    blk_used = mem_rdata[0];
    psz      = prev_w & ALIGN_MSK;
    nsz      = mem_rdata[OW-1:0] & ALIGN_MSK;
  end

  // operand selection for the shared adder and tag write data
  always_comb begin
    alu_a     = bp;
    alu_b     = '0;
    alu_c     = -5'sd4;
    mem_we    = 1'b0;
    mem_wdata = 32'(sz);
    case (state)
      ihla_pkg::S_INIT0: begin
        alu_a = '0; alu_c = 5'sd4; mem_we = 1'b1; mem_wdata = 32'd9;
      end
      ihla_pkg::S_INIT1: begin
        alu_a = '0; alu_c = 5'sd8; mem_we = 1'b1; mem_wdata = 32'd9;
      end
      ihla_pkg::S_INIT2: begin
        alu_a = '0; alu_c = 5'sd12; mem_we = 1'b1; mem_wdata = 32'd1;
      end
      ihla_pkg::S_FIT_CHK: begin
        alu_b = blk_s; alu_c = 5'sd0;
      end
      ihla_pkg::S_GROW_W0: begin
        mem_we = 1'b1;
      end
      ihla_pkg::S_GROW_W1: begin
        alu_b = sz; alu_c = -5'sd8; mem_we = 1'b1;
      end
      ihla_pkg::S_GROW_W2: begin
        alu_b = sz; mem_we = 1'b1; mem_wdata = 32'd1;
      end
      ihla_pkg::S_MRG_RP: begin
        alu_c = -5'sd8;
      end
      ihla_pkg::S_MRG_RN: begin
        alu_b = sz;
      end
      ihla_pkg::S_MRG_W0: begin
        alu_a = mstart; mem_we = 1'b1; mem_wdata = 32'(mtotal);
      end
      ihla_pkg::S_MRG_W1: begin
        alu_a = mstart; alu_b = mtotal; alu_c = -5'sd8;
        mem_we = 1'b1; mem_wdata = 32'(mtotal);
      end
      ihla_pkg::S_PLC_W0: begin
        mem_we = 1'b1; mem_wdata = split ? 32'(asize_w | OW'(1)) : 32'(sz | OW'(1));
      end
      ihla_pkg::S_PLC_W1: begin
        alu_b = split ? asize_w : sz; alu_c = -5'sd8;
        mem_we = 1'b1; mem_wdata = split ? 32'(asize_w | OW'(1)) : 32'(sz | OW'(1));
      end
      ihla_pkg::S_PLC_W2: begin
        alu_b = asize_w; mem_we = 1'b1; mem_wdata = 32'(rem);
      end
      ihla_pkg::S_PLC_W3: begin
        alu_b = sz; alu_c = -5'sd8; mem_we = 1'b1; mem_wdata = 32'(rem);
      end
      ihla_pkg::S_FREE_W0: begin
        mem_we = 1'b1;
      end
      ihla_pkg::S_FREE_W1: begin
        alu_b = sz; alu_c = -5'sd8; mem_we = 1'b1;
      end
      default: begin
        alu_a = bp;
      end
    endcase
  end

  ihla_alu #(.OW(OW)) u_alu (
    .a (alu_a),
    .b (alu_b),
    .c (alu_c),
    .y (alu_y)
  );

  ihla_ram #(.WIDTH(32), .DEPTH(NWORDS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (alu_y[WAW+1:2]),
    .wdata (mem_wdata),
    .raddr (alu_y[WAW+1:2]),
    .rdata (mem_rdata)
  );

  // chunk size register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= ihla_pkg::CHUNK_RESET;
    end else if (chunk_we) begin
      chunk <= chunk_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihla_pkg::S_INIT0;
      brk   <= FIRST_OFS;
      ctx   <= ihla_pkg::CTX_INIT;
    end else begin
      case (state)
        ihla_pkg::S_INIT0: state <= ihla_pkg::S_INIT1;
        ihla_pkg::S_INIT1: state <= ihla_pkg::S_INIT2;
        ihla_pkg::S_INIT2: begin
          if (INIT_FITS) begin
            bp    <= FIRST_OFS;
            sz    <= INIT_SZ;
            ctx   <= ihla_pkg::CTX_INIT;
            state <= ihla_pkg::S_GROW_W0;
          end else begin
            state <= ihla_pkg::S_IDLE;
          end
        end
        ihla_pkg::S_IDLE: begin
          if (start) begin
            func_r     <= func;
            faddr      <= free_addr;
            asize      <= asize_c;
            bp         <= FIRST_OFS;
            res_addr   <= '0;
            res_status <= ihla_pkg::ST_OK;
            if (func == ihla_pkg::FN_ALLOC && req_size == 16'd0) begin
              res_status <= ihla_pkg::ST_ZERO;
              state      <= ihla_pkg::S_DONE;
            end else begin
              state <= ihla_pkg::S_FIT_RD;
            end
          end
        end
        ihla_pkg::S_FIT_RD: begin
          if (func_r == ihla_pkg::FN_ALLOC) begin
            if (bp >= brk) begin
              if (grow_ok) begin
                bp    <= brk;
                sz    <= OW'(ext_c);
                ctx   <= ihla_pkg::CTX_GROW;
                state <= ihla_pkg::S_GROW_W0;
              end else begin
                res_status <= ihla_pkg::ST_NOMEM;
                state      <= ihla_pkg::S_DONE;
              end
            end else begin
              state <= ihla_pkg::S_FIT_CHK;
            end
          end else if (bp < brk && bp <= OW'(faddr)) begin
            state <= ihla_pkg::S_FIT_CHK;
          end else begin
            state <= ihla_pkg::S_DONE;
          end
        end
        ihla_pkg::S_FIT_CHK: begin
          if (func_r == ihla_pkg::FN_ALLOC) begin
            if (blk_s == '0) begin
              if (grow_ok) begin
                bp    <= brk;
                sz    <= OW'(ext_c);
                ctx   <= ihla_pkg::CTX_GROW;
                state <= ihla_pkg::S_GROW_W0;
              end else begin
                res_status <= ihla_pkg::ST_NOMEM;
                state      <= ihla_pkg::S_DONE;
              end
            end else if (!blk_used && asize_w <= blk_s) begin
              sz    <= blk_s;
              state <= ihla_pkg::S_PLC_W0;
            end else begin
              bp    <= alu_y;
              state <= ihla_pkg::S_FIT_RD;
            end
          end else begin
            if (blk_s == '0) begin
              state <= ihla_pkg::S_DONE;
            end else if (bp == OW'(faddr)) begin
              if (blk_used) begin
                sz    <= blk_s;
                ctx   <= ihla_pkg::CTX_FREE;
                state <= ihla_pkg::S_FREE_W0;
              end else begin
                state <= ihla_pkg::S_DONE;
              end
            end else begin
              bp    <= alu_y;
              state <= ihla_pkg::S_FIT_RD;
            end
          end
        end
        ihla_pkg::S_GROW_W0: state <= ihla_pkg::S_GROW_W1;
        ihla_pkg::S_GROW_W1: state <= ihla_pkg::S_GROW_W2;
        ihla_pkg::S_GROW_W2: begin
          brk   <= bp + sz;
          state <= ihla_pkg::S_MRG_RP;
        end
        ihla_pkg::S_FREE_W0: state <= ihla_pkg::S_FREE_W1;
        ihla_pkg::S_FREE_W1: state <= ihla_pkg::S_MRG_RP;
        ihla_pkg::S_MRG_RP:  state <= ihla_pkg::S_MRG_RN;
        ihla_pkg::S_MRG_RN: begin
          prev_w <= mem_rdata[OW-1:0];
          state  <= ihla_pkg::S_MRG_CALC;
        end
        ihla_pkg::S_MRG_CALC: begin
          // coalesce with whichever neighbors are free
          mtotal <= sz + (prev_w[0] ? '0 : psz) + (mem_rdata[0] ? '0 : nsz);
          mstart <= bp - (prev_w[0] ? '0 : psz);
          state  <= ihla_pkg::S_MRG_W0;
        end
        ihla_pkg::S_MRG_W0: state <= ihla_pkg::S_MRG_W1;
        ihla_pkg::S_MRG_W1: begin
          case (ctx)
            ihla_pkg::CTX_GROW: begin
              bp    <= mstart;
              sz    <= mtotal;
              state <= ihla_pkg::S_PLC_W0;
            end
            ihla_pkg::CTX_FREE: state <= ihla_pkg::S_DONE;
            default:            state <= ihla_pkg::S_IDLE;
          endcase
        end
        ihla_pkg::S_PLC_W0: begin
          res_addr <= bp;
          state    <= ihla_pkg::S_PLC_W1;
        end
        ihla_pkg::S_PLC_W1: state <= split ? ihla_pkg::S_PLC_W2 : ihla_pkg::S_DONE;
        ihla_pkg::S_PLC_W2: state <= ihla_pkg::S_PLC_W3;
        ihla_pkg::S_PLC_W3: state <= ihla_pkg::S_DONE;
        ihla_pkg::S_DONE:   state <= ihla_pkg::S_IDLE;
        default:            state <= ihla_pkg::S_IDLE;
      endcase
    end
  end

  // result beat
  assign busy       = state != ihla_pkg::S_IDLE;
  assign done       = state == ihla_pkg::S_DONE;
  assign block_addr = res_addr[15:0];
  assign status     = res_status;

  // an accepted item holds busy until its result beat
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // the result strobe lasts exactly one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // allocated payload offsets are 8-byte aligned
  a_addr_align: assert property (@(posedge clk) disable iff (rst)
    (done && status == ihla_pkg::ST_OK) |-> (block_addr[2:0] == 3'd0))
    else $error("misaligned block address");

  // the break never moves down and stays within the heap
  a_brk_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (brk >= $past(brk) && brk <= HEAP_LIM))
    else $error("heap break moved down or past the heap");

  // no tag write while idle
  a_idle_nowrite: assert property (@(posedge clk) disable iff (rst)
    (state == ihla_pkg::S_IDLE) |-> !mem_we)
    else $error("tag write while idle");

endmodule
`default_nettype wire

/* sim/tb_implicit_list_heap_allocator_top.sv */
// self-checking testbench for the first-fit boundary-tag heap allocator
`timescale 1ns / 1ps
module tb_implicit_list_heap_allocator_top;

  localparam int unsigned HEAP_SZ = 65536;
  localparam int unsigned NW = HEAP_SZ / 4;

  typedef struct {
    logic        fn;
    logic [15:0] size;
    logic [15:0] addr;
  } heap_req_t;

  typedef struct {
    logic [15:0] addr;
    logic [1:0]  st;
  } heap_ans_t;

  logic clk, rst, start, busy, func, chunk_we, done;
  logic [15:0] req_size, free_addr, chunk_wdata, block_addr;
  logic [1:0] status;

  implicit_list_heap_allocator_top #(.HEAP_BYTES(HEAP_SZ)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .req_size(req_size), .free_addr(free_addr), .chunk_we(chunk_we),
    .chunk_wdata(chunk_wdata), .done(done), .block_addr(block_addr), .status(status)
  );

  // shadow heap: tag words, break and chunk register
  bit [31:0]   tag_mem [NW];
  int unsigned brk_off;
  int unsigned chunk_reg;
  int unsigned live_blocks[$];
  int unsigned freed_blocks[$];

  heap_req_t   pend_reqs[$];
  heap_ans_t   due_answers[$];
  logic        taken;
  bit          calm;
  int          errors, n_alloc, n_free, n_nomem, n_zero, n_answers;

  function automatic int unsigned tag_rd(int unsigned off);
    return (off >> 2) < NW ? tag_mem[off >> 2] : 0;
  endfunction

  function automatic void tag_wr(int unsigned off, int unsigned v);
    if ((off >> 2) < NW) tag_mem[off >> 2] = v;
  endfunction

  function automatic int unsigned bsize(int unsigned bp);
    return tag_rd(bp - 4) & ~32'd7;
  endfunction

  // coalesce a free block with free neighbors
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned sz, pu, nu, st, tot;
    sz = bsize(bp);
    pu = tag_rd(bp - 8) & 1;
    nu = tag_rd(bp + sz - 4) & 1;
    st = bp;
    tot = sz;
    if (pu && nu) return bp;
    if (!nu) tot += tag_rd(bp + sz - 4) & ~32'd7;
    if (!pu) begin
      tot += tag_rd(bp - 8) & ~32'd7;
      st = bp - (tag_rd(bp - 8) & ~32'd7);
    end
    tag_wr(st - 4, tot);
    tag_wr(st + tot - 8, tot);
    return st;
  endfunction

  function automatic int unsigned grow_heap(int unsigned nb);
    int unsigned bp;
    bp = brk_off;
    if (nb == 0 || bp + nb > HEAP_SZ) return 0;
    tag_wr(bp - 4, nb);
    tag_wr(bp + nb - 8, nb);
    tag_wr(bp + nb - 4, 1);
    brk_off = bp + nb;
    return coalesce(bp);
  endfunction

  // walk the block list; find first fit or check a used payload offset
  function automatic int unsigned walk_fit(int unsigned asize);
    int unsigned bp, s;
    bp = ihla_pkg::FIRST_BP;
    while (bp < brk_off) begin
      s = bsize(bp);
      if (s == 0) break;
      if (!(tag_rd(bp - 4) & 1) && asize <= s) return bp;
      bp += s;
    end
    return 0;
  endfunction

  function automatic bit is_live(int unsigned a);
    int unsigned bp, s;
    bp = ihla_pkg::FIRST_BP;
    while (bp < brk_off && bp <= a) begin
      s = bsize(bp);
      if (s == 0) break;
      if (bp == a) return (tag_rd(bp - 4) & 1) != 0;
      bp += s;
    end
    return 0;
  endfunction

  function automatic void heap_model_reset();
    foreach (tag_mem[i]) tag_mem[i] = 0;
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    brk_off = ihla_pkg::FIRST_BP;
    chunk_reg = 4096;
    void'(grow_heap(ihla_pkg::INIT_CHUNK));
  endfunction

  // expected answer of one beat, updating the shadow heap
  function automatic heap_ans_t predict_heap_op(heap_req_t r);
    heap_ans_t a;
    int unsigned asize, bp, ext, csz, s;
    a.addr = 0;
    a.st = ihla_pkg::ST_OK;
    if (r.fn == ihla_pkg::FN_FREE) begin
      n_free++;
      if (is_live(r.addr)) begin
        s = bsize(r.addr);
        tag_wr(r.addr - 4, s);
        tag_wr(r.addr + s - 8, s);
        void'(coalesce(r.addr));
        foreach (live_blocks[i]) if (live_blocks[i] == r.addr) begin
          live_blocks.delete(i);
          break;
        end
        freed_blocks.push_back(r.addr);
        if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
      end
    end else if (r.size == 0) begin
      a.st = ihla_pkg::ST_ZERO;
      n_zero++;
    end else begin
      n_alloc++;
      asize = r.size <= 8 ? ihla_pkg::MIN_BLOCK : 8 * ((r.size + 15) / 8);
      bp = walk_fit(asize);
      if (bp == 0) begin
        ext = asize > chunk_reg ? asize : chunk_reg;
        ext = (((ext >> 2) << 2) + 7) & ~32'd7;
        bp = grow_heap(ext);
      end
      if (bp == 0) begin
        a.st = ihla_pkg::ST_NOMEM;
        n_nomem++;
      end else begin
        csz = bsize(bp);
        if (csz - asize >= ihla_pkg::MIN_BLOCK) begin
          tag_wr(bp - 4, asize | 1);
          tag_wr(bp + asize - 8, asize | 1);
          tag_wr(bp + asize - 4, csz - asize);
          tag_wr(bp + csz - 8, csz - asize);
        end else begin
          tag_wr(bp - 4, csz | 1);
          tag_wr(bp + csz - 8, csz | 1);
        end
        a.addr = bp[15:0];
        live_blocks.push_back(bp);
      end
    end
    return a;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: one beat per start/!busy handshake
  always @(negedge clk) begin
    heap_req_t r;
    if (rst) begin
      start <= 0;
    end else if (!start || taken) begin
      if (pend_reqs.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
        r = pend_reqs.pop_front();
        start <= 1;
        func <= r.fn;
        req_size <= r.size;
        free_addr <= r.addr;
      end else begin
        start <= 0;
      end
    end
  end

  // monitor: check answers, then predict accepted beats
  always @(posedge clk) begin
    heap_ans_t e;
    heap_req_t r;
    if (!rst && done) begin
      n_answers++;
      if (due_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected answer addr=%0d status=%0d", block_addr, status);
      end else begin
        e = due_answers.pop_front();
        if (e.addr !== block_addr || e.st !== status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp addr=%0d status=%0d got addr=%0d status=%0d",
                     e.addr, e.st, block_addr, status);
        end
      end
    end
    taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      r.fn = func;
      r.size = req_size;
      r.addr = free_addr;
      due_answers.push_back(predict_heap_op(r));
    end
  end

  task automatic send(logic fn, logic [15:0] sz, logic [15:0] ad);
    heap_req_t r;
    r.fn = fn;
    r.size = sz;
    r.addr = ad;
    pend_reqs.push_back(r);
    while (pend_reqs.size() != 0 || due_answers.size() != 0 || start) @(posedge clk);
  endtask

  task automatic write_chunk(int unsigned v);
    repeat (4) @(posedge clk);
    @(negedge clk);
    chunk_we <= 1;
    chunk_wdata <= v[15:0];
    @(negedge clk);
    chunk_we <= 0;
    chunk_reg = v & 16'hffff;
  endtask

  task automatic random_beat();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) begin
      if (p < 3) send(ihla_pkg::FN_ALLOC, 0, 16'($urandom));
      else if (p < 6) send(ihla_pkg::FN_ALLOC, 16'($urandom), 16'($urandom));
      else if (p < 12)
        send(ihla_pkg::FN_ALLOC, 16'($urandom_range(4096, 200)), 16'($urandom));
      else send(ihla_pkg::FN_ALLOC, 16'($urandom_range(64, 1)), 16'($urandom));
    end else if (p < 85 && live_blocks.size() != 0) begin
      send(ihla_pkg::FN_FREE, 16'($urandom),
           16'(live_blocks[$urandom_range(live_blocks.size() - 1)]));
    end else if (p < 92 && freed_blocks.size() != 0) begin
      send(ihla_pkg::FN_FREE, 16'($urandom),
           16'(freed_blocks[$urandom_range(freed_blocks.size() - 1)]));
    end else begin
      send(ihla_pkg::FN_FREE, 16'($urandom), 16'($urandom));
    end
  endtask

  int unsigned chunk_plan[7] = '{16, 32768, 13, 0, 65535, 200, 4096};

  // stimulus
  initial begin
    int unsigned a, b, c, d;
    rst = 1;
    start = 0;
    func = ihla_pkg::FN_ALLOC;
    req_size = 0;
    free_addr = 0;
    chunk_we = 0;
    chunk_wdata = 0;
    taken = 0;
    calm = 0;
    heap_model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: size extremes, bad frees, no-merge, next-only and both-sides coalesces, out of memory
    send(ihla_pkg::FN_ALLOC, 0, 0);
    send(ihla_pkg::FN_ALLOC, 1, 16'hffff);
    send(ihla_pkg::FN_ALLOC, 8, 0);
    send(ihla_pkg::FN_ALLOC, 9, 0);
    send(ihla_pkg::FN_FREE, 0, 0);
    send(ihla_pkg::FN_FREE, 16'hffff, 16'hffff);
    send(ihla_pkg::FN_FREE, 0, 16'd17);
    live_blocks.delete();
    send(ihla_pkg::FN_ALLOC, 24, 0); a = live_blocks[$];
    send(ihla_pkg::FN_ALLOC, 40, 0); b = live_blocks[$];
    send(ihla_pkg::FN_ALLOC, 56, 0); c = live_blocks[$];
    send(ihla_pkg::FN_ALLOC, 72, 0); d = live_blocks[$];
    send(ihla_pkg::FN_FREE, 0, 16'(b));
    send(ihla_pkg::FN_FREE, 0, 16'(a));
    send(ihla_pkg::FN_FREE, 0, 16'(d));
    send(ihla_pkg::FN_FREE, 0, 16'(c));
    send(ihla_pkg::FN_FREE, 0, 16'(c));
    send(ihla_pkg::FN_ALLOC, 4000, 0);
    send(ihla_pkg::FN_ALLOC, 16'hffff, 0);
    send(ihla_pkg::FN_ALLOC, 16'd30000, 0);
    send(ihla_pkg::FN_ALLOC, 16'd30000, 0);

    // random phases at several chunk settings, long calm stretch mid-run
    foreach (chunk_plan[k]) begin
      write_chunk(chunk_plan[k]);
      calm = (k == 3);
      repeat (200) random_beat();
    end
    calm = 0;

    repeat (40) @(posedge clk);
    $display("covered %0d allocates, %0d frees, %0d zero-size, %0d out-of-memory",
             n_alloc, n_free, n_zero, n_nomem);
    $display("checked %0d answers over %0d chunk settings, %0d errors",
             n_answers, 8, errors);
    if (errors == 0 && due_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000_000;
    $display("timeout with %0d answers outstanding", due_answers.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
